### src/lodccs_pkg.sv
// Package for the LOD cluster cut selector: types, codes, constants and helpers.
`timescale 1ns / 1ps

package lodccs_pkg;

  // Table depth default
  localparam int MaxGroupsDefault = 1024;

  // Pipeline depth from the memory read register to the result register
  localparam int LAT = 24;

  // Input item kinds
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TEST = 1'b1
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_PARENT  = 2'd1,
    ST_BAD_REFINED = 2'd2
  } status_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_CAMERA_X   = 3'd0,
    REG_CAMERA_Y   = 3'd1,
    REG_CAMERA_Z   = 3'd2,
    REG_NEAR_PLANE = 3'd3,
    REG_PROJ_GAIN  = 3'd4,
    REG_ERR_LIMIT  = 3'd5,
    REG_GROUP_CNT  = 3'd6,
    REG_PROJ_MODE  = 3'd7
  } cfg_reg_t;

  // Reset values
  localparam logic [31:0] NearPlaneReset = 32'd6554;
  localparam logic [31:0] ProjGainReset  = 32'd65536;
  localparam logic [31:0] ErrLimitReset  = 32'd65536;

  // Configuration register set
  typedef struct packed {
    logic [31:0] camera_x;
    logic [31:0] camera_y;
    logic [31:0] camera_z;
    logic [31:0] near_plane;
    logic [31:0] projection_gain;
    logic [31:0] error_limit;
    logic [10:0] group_count;
    logic        projected_mode;
  } cfg_t;

  // One group table entry
  typedef struct packed {
    logic [31:0] center_x;
    logic [31:0] center_y;
    logic [31:0] center_z;
    logic [31:0] radius;
    logic [31:0] error;
    logic        terminal;
  } entry_t;

  // Partial square root state
  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] root;
  } sqrt_st_t;

  // Magnitude of the difference of two signed 32-bit values
  function automatic logic [31:0] abs_diff(logic [31:0] a, logic [31:0] b);
    logic signed [32:0] d;
    logic [32:0] m;
    d = $signed({a[31], a}) - $signed({b[31], b});
    m = d[32] ? 33'(-d) : 33'(d);
    return m[31:0];
  endfunction

  // Resolve one root bit: keep it if the trial square still fits the remainder
  function automatic sqrt_st_t sqrt_step(sqrt_st_t s, int i);
    logic [63:0] trial;
    sqrt_st_t o;
    trial = (64'(s.root) << (i + 1)) | (64'd1 << (2 * i));
    o = s;
    if (s.rem >= trial) begin
      o.rem  = s.rem - trial;
      o.root = s.root | (32'd1 << i);
    end
    return o;
  endfunction

endpackage

### src/lodccs_lane.sv
// Error test lane: distance, denominator and cross-multiplied limit compare.
`timescale 1ns / 1ps

module lodccs_lane (
  input  logic                      clk,
  input  logic [lodccs_pkg::LAT:1]  en,
  input  lodccs_pkg::entry_t        ent,
  input  lodccs_pkg::cfg_t          cfg,
  output logic                      above
);

  localparam int SqrtStages = 16;

  logic [31:0] m2 [3];
  logic [31:0] e2, r2;
  logic        t2;

  logic [63:0] sq3 [3];
  logic [31:0] e3, r3;
  logic        t3;

  logic [64:0] s4;
  logic [63:0] sqz4;
  logic [31:0] e4, r4;
  logic        t4;

  logic [65:0] n5;

  lodccs_pkg::sqrt_st_t sq_st [SqrtStages+1];
  logic        sat_p [SqrtStages+1];
  logic [31:0] e_p   [SqrtStages+1];
  logic [31:0] r_p   [SqrtStages+1];
  logic        t_p   [SqrtStages+1];

  logic [31:0] cam_range;
  logic [32:0] gap;
  logic [31:0] den;
  logic [31:0] den22, e22;
  logic        t22;

  logic [63:0] p23, q23;
  logic [31:0] e23;
  logic        t23;

  // Stage 2: magnitudes of the camera offsets
  always_ff @(posedge clk) begin
    if (en[2]) begin
      m2[0] <= lodccs_pkg::abs_diff(ent.center_x, cfg.camera_x);
      m2[1] <= lodccs_pkg::abs_diff(ent.center_y, cfg.camera_y);
      m2[2] <= lodccs_pkg::abs_diff(ent.center_z, cfg.camera_z);
      e2    <= ent.error;
      r2    <= ent.radius;
      t2    <= ent.terminal;
    end
  end

  // Stage 3: squares
  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < 3; i++) begin
        sq3[i] <= 64'(m2[i]) * 64'(m2[i]);
      end
      e3 <= e2;
      r3 <= r2;
      t3 <= t2;
    end
  end

  // Stage 4: first partial sum
  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4   <= 65'(sq3[0]) + 65'(sq3[1]);
      sqz4 <= sq3[2];
      e4   <= e3;
      r4   <= r3;
      t4   <= t3;
    end
  end

  // Stage 5: full sum, saturate on overflow of 64 bits
  assign n5 = 66'(s4) + 66'(sqz4);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      sq_st[0] <= '{rem: n5[63:0], root: 32'd0};
      sat_p[0] <= |n5[65:64];
      e_p[0]   <= e4;
      r_p[0]   <= r4;
      t_p[0]   <= t4;
    end
  end

  // Stages 6 to 21: two root bits per stage
  for (genvar j = 0; j < SqrtStages; j++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (en[6+j]) begin
        sq_st[j+1] <= lodccs_pkg::sqrt_step(
                        lodccs_pkg::sqrt_step(sq_st[j], 31 - 2 * j), 30 - 2 * j);
        sat_p[j+1] <= sat_p[j];
        e_p[j+1]   <= e_p[j];
        r_p[j+1]   <= r_p[j];
        t_p[j+1]   <= t_p[j];
      end
    end
  end

  // Stage 22: denominator, clamped below by the near plane and by one
  assign cam_range = sat_p[SqrtStages] ? 32'hFFFF_FFFF : sq_st[SqrtStages].root;
  assign gap       = {1'b0, cam_range} - {1'b0, r_p[SqrtStages]};

  always_comb begin
    den = cfg.near_plane;
    if (cam_range > r_p[SqrtStages] && gap[31:0] > cfg.near_plane) begin
      den = gap[31:0];
    end
    if (den == 32'd0) begin
      den = 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[22]) begin
      den22 <= den;
      e22   <= e_p[SqrtStages];
      t22   <= t_p[SqrtStages];
    end
  end

  // Stage 23: cross products
  always_ff @(posedge clk) begin
    if (en[23]) begin
      p23 <= 64'(e22) * 64'(cfg.projection_gain);
      q23 <= 64'(den22) * 64'(cfg.error_limit);
      e23 <= e22;
      t23 <= t22;
    end
  end

  // Stage 24: error above limit, terminal counts as infinite
  always_ff @(posedge clk) begin
    if (en[24]) begin
      if (t23) begin
        above <= 1'b1;
      end else if (cfg.projected_mode) begin
        above <= {1'b0, p23} > {q23, 1'b0};
      end else begin
        above <= e23 > cfg.error_limit;
      end
    end
  end

endmodule

### src/lod_cluster_cut_select.sv
// Top level of the LOD cluster cut selector: group table, pipeline control, ports.
//
//  channel  dir  handshake                 payload
//  s_*      in   s_tvalid / s_tready       s_tdata (item fields), s_tuser (operation)
//  m_*      out  m_tvalid / m_tready       m_tdata (cluster, selected, status)
//  cfg_*    in   cfg_valid / cfg_ready     cfg_index, cfg_data
//
//  One item per cycle unless m_tready holds the result; a test result passes the table read,
//  then the sixteen-stage square root (two root bits a stage), then the compare.
//  Load items write the table at their transfer and give no result.
//  Reset sets the registers to defaults and empties the pipeline; the table is not cleared.
//  Each stage holds only while the stage after it is full and held, so bubbles close up.
`timescale 1ns / 1ps

module lod_cluster_cut_select #(
  parameter int MAX_GROUPS = lodccs_pkg::MaxGroupsDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [9:0] group_slot, [41:10] center_x, [73:42] center_y, [105:74] center_z,
  // [137:106] bound_radius, [169:138] group_error, [170] error_terminal,
  // [194:171] cluster_id, [205:195] parent_group, [216:206] refined_group
  input  logic [223:0] s_tdata,
  // [0] operation
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [23:0] result_cluster, [24] selected, [26:25] status
  output logic [31:0]  m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int AW  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int LAT = lodccs_pkg::LAT;

  lodccs_pkg::cfg_t   cfg;
  lodccs_pkg::entry_t mem [MAX_GROUPS];
  lodccs_pkg::entry_t in_ent, rd_par, rd_ref;

  logic [9:0]  in_slot;
  logic [23:0] in_cluster;
  logic [10:0] in_par, in_ref;
  logic        in_xfer, par_ok, ref_ok;
  lodccs_pkg::status_t in_status;

  logic [LAT:1] v, en;
  logic [23:0]  cl_q [LAT:1];
  lodccs_pkg::status_t st_q [LAT:1];
  logic         rn_q [LAT:1];
  logic         above_par, above_ref, sel;

  // Unpack the item
  assign in_slot         = s_tdata[9:0];
  assign in_ent.center_x = s_tdata[41:10];
  assign in_ent.center_y = s_tdata[73:42];
  assign in_ent.center_z = s_tdata[105:74];
  assign in_ent.radius   = s_tdata[137:106];
  assign in_ent.error    = s_tdata[169:138];
  assign in_ent.terminal = s_tdata[170];
  assign in_cluster      = s_tdata[194:171];
  assign in_par          = s_tdata[205:195];
  assign in_ref          = s_tdata[216:206];

  assign in_xfer = s_tvalid && s_tready;

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{camera_x: 32'd0, camera_y: 32'd0, camera_z: 32'd0,
               near_plane: lodccs_pkg::NearPlaneReset,
               projection_gain: lodccs_pkg::ProjGainReset,
               error_limit: lodccs_pkg::ErrLimitReset,
               group_count: 11'd0, projected_mode: 1'b1};
    end else if (cfg_valid) begin
      case (lodccs_pkg::cfg_reg_t'(cfg_index))
        lodccs_pkg::REG_CAMERA_X:   cfg.camera_x        <= cfg_data;
        lodccs_pkg::REG_CAMERA_Y:   cfg.camera_y        <= cfg_data;
        lodccs_pkg::REG_CAMERA_Z:   cfg.camera_z        <= cfg_data;
        lodccs_pkg::REG_NEAR_PLANE: cfg.near_plane      <= cfg_data;
        lodccs_pkg::REG_PROJ_GAIN:  cfg.projection_gain <= cfg_data;
        lodccs_pkg::REG_ERR_LIMIT:  cfg.error_limit     <= cfg_data;
        lodccs_pkg::REG_GROUP_CNT:  cfg.group_count     <= cfg_data[10:0];
        lodccs_pkg::REG_PROJ_MODE:  cfg.projected_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Index checks on the incoming test item
  assign par_ok = !in_par[10] && (in_par < cfg.group_count) &&
                  (17'(in_par[9:0]) < 17'(MAX_GROUPS));
  assign ref_ok = !in_ref[10] && (in_ref < cfg.group_count) &&
                  (17'(in_ref[9:0]) < 17'(MAX_GROUPS));

  always_comb begin
    if (!par_ok) begin
      in_status = lodccs_pkg::ST_BAD_PARENT;
    end else if (!in_ref[10] && !ref_ok) begin
      in_status = lodccs_pkg::ST_BAD_REFINED;
    end else begin
      in_status = lodccs_pkg::ST_OK;
    end
  end

  // Stage enables: a stage moves when empty or when the next one moves
  assign en[LAT] = !v[LAT] || m_tready;
  for (genvar k = 1; k < LAT; k++) begin : g_en
    assign en[k] = !v[k] || en[k+1];
  end
  assign s_tready = en[1];

  // Group table: load writes, two registered reads for the test
  always_ff @(posedge clk) begin
    if (in_xfer && lodccs_pkg::op_t'(s_tuser) == lodccs_pkg::OP_LOAD &&
        17'(in_slot) < 17'(MAX_GROUPS)) begin
      mem[AW'(in_slot)] <= in_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      rd_par <= mem[AW'(in_par[9:0])];
      rd_ref <= mem[AW'(in_ref[9:0])];
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= s_tvalid && lodccs_pkg::op_t'(s_tuser) == lodccs_pkg::OP_TEST;
      end
      for (int k = 2; k <= LAT; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // Item side payload, advanced alongside the lanes
  always_ff @(posedge clk) begin
    if (en[1]) begin
      cl_q[1] <= in_cluster;
      st_q[1] <= in_status;
      rn_q[1] <= in_ref[10];
    end
    for (int k = 2; k <= LAT; k++) begin
      if (en[k]) begin
        cl_q[k] <= cl_q[k-1];
        st_q[k] <= st_q[k-1];
        rn_q[k] <= rn_q[k-1];
      end
    end
  end

  // Parent and refined lanes
  lodccs_lane u_lane_par (
    .clk   (clk),
    .en    (en),
    .ent   (rd_par),
    .cfg   (cfg),
    .above (above_par)
  );

  lodccs_lane u_lane_ref (
    .clk   (clk),
    .en    (en),
    .ent   (rd_ref),
    .cfg   (cfg),
    .above (above_ref)
  );

  // Cut decision and result
  assign sel = (st_q[LAT] == lodccs_pkg::ST_OK) && above_par &&
               (rn_q[LAT] || !above_ref);

  assign m_tvalid = v[LAT];
  assign m_tdata  = {5'd0, st_q[LAT], sel, cl_q[LAT]};

endmodule
